>>> hdl/qph_pkg.sv
// shared constants and codes for the quadratic probe hash table
package qph_pkg;

    // store geometry
    localparam int DEPTH   = 1024;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CAP_W   = IDX_W + 1;
    localparam int KEY_W   = 64;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int WORD_W  = ST_W + KEY_W + VAL_W;

    // hash mixing
    localparam logic [KEY_W-1:0] MIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [KEY_W-1:0] MIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int               MIX_SHIFT = 33;
    localparam int               MOD_BITS  = 4;
    localparam int               MOD_STEPS = KEY_W / MOD_BITS;
    localparam int               MOD_CNT_W = $clog2(MOD_STEPS);

    // configuration
    localparam logic             REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(1021);

    // commands, the spare code behaves as a get
    localparam logic [1:0] CMD_GET    = 2'd0;
    localparam logic [1:0] CMD_PUT    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    // result status
    localparam logic [1:0] RES_FOUND    = 2'd0;
    localparam logic [1:0] RES_INSERTED = 2'd1;
    localparam logic [1:0] RES_NOTFOUND = 2'd2;
    localparam logic [1:0] RES_FULL     = 2'd3;

    // slot status
    localparam logic [ST_W-1:0] SLOT_FREE = 2'd0;
    localparam logic [ST_W-1:0] SLOT_USED = 2'd1;
    localparam logic [ST_W-1:0] SLOT_DEL  = 2'd2;

endpackage

>>> hdl/quadratic_probe_hash_table.sv
// top level: command sequencer, slot store and probe walk
//
//   channel   | signals                                   | direction
//   ----------+-------------------------------------------+----------
//   command   | i_valid o_ready i_cmd i_key i_value_in     | in
//   result    | o_valid i_ready o_status o_value_out       | out
//             | o_live_entries                            |
//   config    | psel penable pwrite paddr pwdata prdata    | in/out
//
// an operation first hashes the key (6 multiply steps, 16 remainder steps of 4
// bits, then the start slot is handed over), then reads and evaluates each slot probed
// through the single-read slot ram, then loads the result register
// after reset a clearing pass writes all 1024 slots free, with
// o_ready low; configuration beats are taken throughout
// one operation at a time; a held result does not block the next command beat,
// but the following result waits in the output state until the held one is taken
module quadratic_probe_hash_table import qph_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [1:0]              i_cmd,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic [VAL_W-1:0]        i_value_in,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [1:0]              o_status,
    output logic [VAL_W-1:0]        o_value_out,
    output logic [CAP_W-1:0]        o_live_entries,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_HASH, S_RD, S_EV, S_OUT} t_state;

    t_state           r_state;
    logic [CAP_W-1:0] r_capacity;
    logic [CAP_W-1:0] r_count;
    logic [IDX_W-1:0] r_clr;
    logic [1:0]       r_cmd;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_inc;
    logic [IDX_W-1:0] r_t;
    logic [CAP_W-1:0] r_n;
    logic             r_have_del;
    logic [IDX_W-1:0] r_del_idx;
    logic [1:0]       r_res_status;
    logic [VAL_W-1:0] r_res_val;
    logic             r_ovalid;
    logic [1:0]       r_status;
    logic [VAL_W-1:0] r_vout;
    logic [CAP_W-1:0] r_live;

    logic [CAP_W-1:0]  cap_used;
    logic [IDX_W-1:0]  t_start;
    logic              hash_done;
    logic [IDX_W-1:0]  hash_idx;
    logic              cfg_wr;
    logic [CAP_W-1:0]  sum_idx;
    logic [CAP_W-1:0]  sum_inc;
    logic [CAP_W-1:0]  sum_t;
    logic [IDX_W-1:0]  n_idx;
    logic [IDX_W-1:0]  n_inc;
    logic [IDX_W-1:0]  n_t;
    logic              last_probe;
    logic [WORD_W-1:0] rdata;
    logic [ST_W-1:0]   rd_st;
    logic [KEY_W-1:0]  rd_key;
    logic [VAL_W-1:0]  rd_val;
    logic              ev_hit;
    logic              ev_free;
    logic [IDX_W-1:0]  ins_idx;
    logic              load_ok;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              accept;

    // capacity saturated into 2..DEPTH
    always_comb begin
        cap_used = r_capacity;
        if (r_capacity < CAP_W'(2)) begin
            cap_used = CAP_W'(2);
        end else if (r_capacity > CAP_W'(DEPTH)) begin
            cap_used = CAP_W'(DEPTH);
        end
    end

    // first step of the odd increment series, 3 mod capacity
    always_comb begin
        t_start = IDX_W'(3);
        if (cap_used == CAP_W'(2)) begin
            t_start = IDX_W'(1);
        end else if (cap_used == CAP_W'(3)) begin
            t_start = IDX_W'(0);
        end
    end

    // apb port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? 32'(r_capacity) : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
            r_capacity <= pwdata[CAP_W-1:0];
        end
    end

    // hash unit
    qph_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_key   (i_key),
        .i_cap   (cap_used),
        .o_done  (hash_done),
        .o_idx   (hash_idx)
    );

    // next probe slot: idx + off^2, with off^2 and 2*off+1 kept mod capacity
    assign sum_idx    = {1'b0, r_idx} + {1'b0, r_inc};
    assign sum_inc    = {1'b0, r_inc} + {1'b0, r_t};
    assign sum_t      = {1'b0, r_t} + CAP_W'(2);
    assign n_idx      = (sum_idx >= cap_used) ? IDX_W'(sum_idx - cap_used) : sum_idx[IDX_W-1:0];
    assign n_inc      = (sum_inc >= cap_used) ? IDX_W'(sum_inc - cap_used) : sum_inc[IDX_W-1:0];
    assign n_t        = (sum_t >= cap_used) ? IDX_W'(sum_t - cap_used) : sum_t[IDX_W-1:0];
    assign last_probe = (r_n + 1'b1) == cap_used;

    // slot word fields
    assign rd_st   = rdata[WORD_W-1 -: ST_W];
    assign rd_key  = rdata[VAL_W +: KEY_W];
    assign rd_val  = rdata[VAL_W-1:0];
    assign ev_hit  = (rd_st == SLOT_USED) && (rd_key == r_key);
    assign ev_free = (rd_st != SLOT_USED) && (rd_st != SLOT_DEL);
    assign ins_idx = r_have_del ? r_del_idx : r_idx;
    assign load_ok = ({r_count, 2'b00} + 13'd4) <= (13'(cap_used) * 13'd3);

    // slot writes: clearing pass and write back of the evaluated slot
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = {SLOT_USED, r_key, r_val};
        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_EV: begin
                if (ev_hit) begin
                    if (r_cmd == CMD_PUT) begin
                        ram_we = 1'b1;
                    end else if (r_cmd == CMD_REMOVE) begin
                        ram_we    = 1'b1;
                        ram_wdata = {SLOT_DEL, r_key, rd_val};
                    end
                end else if (ev_free && r_cmd == CMD_PUT && load_ok) begin
                    ram_we    = 1'b1;
                    ram_waddr = ins_idx;
                end
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    qph_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // operation sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == IDX_W'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_cmd   <= i_cmd;
                        r_key   <= i_key;
                        r_val   <= i_value_in;
                        r_state <= S_HASH;
                    end
                end
                S_HASH: begin
                    if (hash_done) begin
                        r_idx      <= hash_idx;
                        r_inc      <= IDX_W'(1);
                        r_t        <= t_start;
                        r_n        <= '0;
                        r_have_del <= 1'b0;
                        r_state    <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_EV;
                end
                S_EV: begin
                    if (ev_hit) begin
                        r_state      <= S_OUT;
                        r_res_status <= RES_FOUND;
                        if (r_cmd == CMD_PUT) begin
                            r_res_val <= r_val;
                        end else if (r_cmd == CMD_REMOVE) begin
                            r_res_val <= '0;
                            if (r_count != '0) begin
                                r_count <= r_count - 1'b1;
                            end
                        end else begin
                            r_res_val <= rd_val;
                        end
                    end else if (ev_free) begin
                        r_state <= S_OUT;
                        if (r_cmd == CMD_PUT && load_ok) begin
                            r_res_status <= RES_INSERTED;
                            r_res_val    <= r_val;
                            r_count      <= r_count + 1'b1;
                        end else begin
                            r_res_val    <= '0;
                            r_res_status <= (r_cmd == CMD_PUT) ? RES_FULL : RES_NOTFOUND;
                        end
                    end else begin
                        // tombstone or other key: remember first tombstone, go on
                        if (rd_st == SLOT_DEL && !r_have_del) begin
                            r_have_del <= 1'b1;
                            r_del_idx  <= r_idx;
                        end
                        if (last_probe) begin
                            r_state      <= S_OUT;
                            r_res_val    <= '0;
                            r_res_status <= (r_cmd == CMD_PUT) ? RES_FULL : RES_NOTFOUND;
                        end else begin
                            r_idx   <= n_idx;
                            r_inc   <= n_inc;
                            r_t     <= n_t;
                            r_n     <= r_n + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_status <= r_res_status;
                        r_vout   <= r_res_val;
                        r_live   <= r_count;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_value_out    = r_vout;
    assign o_live_entries = r_live;

endmodule

>>> hdl/qph_ram.sv
// generic single write port ram with registered read
module qph_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/qph_hash.sv
// key mixer and start index reduction modulo the capacity
module qph_hash import qph_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [KEY_W-1:0] i_key,
    input  logic [CAP_W-1:0] i_cap,
    output logic             o_done,
    output logic [IDX_W-1:0] o_idx
);

    typedef enum logic [1:0] {H_IDLE, H_MUL, H_MOD} t_hstate;

    t_hstate              r_state;
    logic [KEY_W-1:0]     r_h;
    logic [KEY_W-1:0]     r_acc;
    logic [1:0]           r_ph;
    logic                 r_sel;
    logic [MOD_CNT_W-1:0] r_cnt;
    logic [CAP_W-1:0]     r_rem;
    logic                 r_done;

    logic [31:0]      mul_a;
    logic [31:0]      mul_b;
    logic [KEY_W-1:0] mul_c;
    logic [KEY_W-1:0] prod;
    logic [KEY_W-1:0] acc_sum;
    logic [KEY_W-1:0] mixed;
    logic [KEY_W-1:0] remapped;
    logic [CAP_W-1:0] n_rem;
    logic [CAP_W:0]   ext;

    // one 32x32 partial product per cycle, low 64 bits only
    assign mul_c   = r_sel ? MIX_C2 : MIX_C1;
    assign mul_a   = (r_ph == 2'd1) ? r_h[KEY_W-1:32] : r_h[31:0];
    assign mul_b   = (r_ph == 2'd2) ? mul_c[KEY_W-1:32] : mul_c[31:0];
    assign prod    = KEY_W'(mul_a) * KEY_W'(mul_b);
    assign acc_sum = r_acc + {prod[31:0], 32'b0};
    assign mixed   = acc_sum ^ (acc_sum >> MIX_SHIFT);

    // zero and all-ones are remapped
    always_comb begin
        remapped = mixed;
        if (mixed == '0) begin
            remapped = KEY_W'(1);
        end else if (mixed == '1) begin
            remapped = ~KEY_W'(1);
        end
    end

    // restoring remainder, a few bits per cycle
    always_comb begin
        n_rem = r_rem;
        ext   = '0;
        for (int k = 0; k < MOD_BITS; k++) begin
            ext = {n_rem, r_h[KEY_W-1-k]};
            if (ext >= {1'b0, i_cap}) begin
                ext = ext - {1'b0, i_cap};
            end
            n_rem = ext[CAP_W-1:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
            r_ph    <= '0;
            r_sel   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                H_IDLE: begin
                    r_done <= 1'b0;
                    if (i_start) begin
                        r_h     <= i_key ^ (i_key >> MIX_SHIFT);
                        r_ph    <= 2'd0;
                        r_sel   <= 1'b0;
                        r_state <= H_MUL;
                    end
                end
                H_MUL: begin
                    case (r_ph)
                        2'd0: begin
                            r_acc <= prod;
                            r_ph  <= 2'd1;
                        end
                        2'd1: begin
                            r_acc <= acc_sum;
                            r_ph  <= 2'd2;
                        end
                        default: begin
                            r_ph <= 2'd0;
                            if (r_sel) begin
                                r_h     <= remapped;
                                r_rem   <= '0;
                                r_cnt   <= '0;
                                r_state <= H_MOD;
                            end else begin
                                r_h   <= mixed;
                                r_sel <= 1'b1;
                            end
                        end
                    endcase
                end
                H_MOD: begin
                    r_rem  <= n_rem;
                    r_h    <= r_h << MOD_BITS;
                    r_cnt  <= r_cnt + 1'b1;
                    r_done <= (r_cnt == MOD_CNT_W'(MOD_STEPS - 1));
                    if (r_cnt == MOD_CNT_W'(MOD_STEPS - 1)) begin
                        r_state <= H_IDLE;
                    end
                end
                default: begin
                    r_done  <= 1'b0;
                    r_state <= H_IDLE;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_idx  = r_rem[IDX_W-1:0];

endmodule

>>> sim/tb_quadratic_probe_hash_table.sv
// testbench for the quadratic probe hash table: table predictor, random ops, result checks
`timescale 1ns / 1ps

module tb_quadratic_probe_hash_table;
    import qph_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [1:0]              i_cmd;
    logic signed [KEY_W-1:0] i_key;
    logic [VAL_W-1:0]        i_value_in;
    logic                    o_valid;
    logic                    i_ready;
    logic [1:0]              o_status;
    logic [VAL_W-1:0]        o_value_out;
    logic [CAP_W-1:0]        o_live_entries;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    quadratic_probe_hash_table dut (.*);

    // expected result of one operation
    typedef struct packed {
        logic [1:0]       status;
        logic [VAL_W-1:0] value;
        logic [CAP_W-1:0] live;
    } t_op_result;

    // mirror of the table
    logic [ST_W-1:0]  tbl_state [DEPTH];
    logic [KEY_W-1:0] tbl_key   [DEPTH];
    logic [VAL_W-1:0] tbl_val   [DEPTH];
    int unsigned      tbl_live;
    int unsigned      tbl_cap;

    t_op_result  pending_results[$];
    logic [KEY_W-1:0] known_keys[$];
    int          errors;
    int          idle_pct;
    bit          rx_hold;
    int          stall_cycles;
    bit          done;

    // clock, 4 ns period
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [KEY_W-1:0] murmur_mix(logic [KEY_W-1:0] k);
        logic [KEY_W-1:0] h;
        h = k;
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_C1;
        h = h ^ (h >> MIX_SHIFT);
        h = h * MIX_C2;
        h = h ^ (h >> MIX_SHIFT);
        if (h == '0) h = 64'd1;
        else if (h == '1) h = '1 - 64'd1;
        return h;
    endfunction

    function automatic int unsigned eff_cap();
        if (tbl_cap < 2) return 2;
        if (tbl_cap > DEPTH) return DEPTH;
        return tbl_cap;
    endfunction

    // walks the probe path and applies one operation to the mirror
    function automatic t_op_result apply_table_op(logic [1:0] cmd, logic [KEY_W-1:0] key,
                                                  logic [VAL_W-1:0] val);
        t_op_result  r;
        int unsigned cap, idx, hit, ins, del_idx, n;
        longint unsigned off;
        bit          have_del;
        int          outcome;
        cap = eff_cap();
        idx = int'(murmur_mix(key) % 64'(cap));
        off = 1;
        have_del = 0;
        del_idx = 0;
        outcome = 0;
        hit = 0;
        ins = 0;
        for (n = 0; n < cap; n++) begin
            if (tbl_state[idx] == SLOT_DEL) begin
                if (!have_del) begin
                    have_del = 1;
                    del_idx = idx;
                end
            end else if (tbl_state[idx] == SLOT_USED) begin
                if (tbl_key[idx] == key) begin
                    hit = idx;
                    outcome = 1;
                    break;
                end
            end else begin
                ins = have_del ? del_idx : idx;
                outcome = 2;
                break;
            end
            idx = int'((64'(idx) + off * off) % 64'(cap));
            off++;
        end
        r.value = '0;
        if (cmd == CMD_PUT) begin
            if (outcome == 1) begin
                tbl_val[hit] = val;
                r.status = RES_FOUND;
                r.value = val;
            end else if (outcome == 2 && 4 * (tbl_live + 1) <= 3 * cap) begin
                tbl_state[ins] = SLOT_USED;
                tbl_key[ins] = key;
                tbl_val[ins] = val;
                tbl_live++;
                r.status = RES_INSERTED;
                r.value = val;
            end else begin
                r.status = RES_FULL;
            end
        end else if (cmd == CMD_REMOVE) begin
            if (outcome == 1) begin
                tbl_state[hit] = SLOT_DEL;
                if (tbl_live > 0) tbl_live--;
                r.status = RES_FOUND;
            end else begin
                r.status = RES_NOTFOUND;
            end
        end else begin
            if (outcome == 1) begin
                r.status = RES_FOUND;
                r.value = tbl_val[hit];
            end else begin
                r.status = RES_NOTFOUND;
            end
        end
        r.live = CAP_W'(tbl_live);
        return r;
    endfunction

    // send one command beat, with random gaps before it
    task automatic send_op(logic [1:0] cmd, logic [KEY_W-1:0] key, logic [VAL_W-1:0] val);
        while ($urandom_range(99) < idle_pct) @(posedge i_clk);
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_key      <= key;
        i_value_in <= val;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_results.push_back(apply_table_op(cmd, key, val));
        if (cmd == CMD_PUT) known_keys.push_back(key);
        // valid drops while the block starts on the beat
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [31:0] cap);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_CAPACITY);
        pwdata  <= cap;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tbl_cap = cap & 32'h7ff;
    endtask

    // drain all results, then let the probe walk settle
    task automatic wait_quiet();
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(99) < 60)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        if ($urandom_range(3) == 0) return 64'($urandom_range(15));
        return {$urandom, $urandom};
    endfunction

    task automatic test_extremes();
        logic [KEY_W-1:0] edge_keys[6];
        edge_keys = '{64'h8000000000000000, 64'h7fffffffffffffff, 64'h0,
                      64'hffffffffffffffff, 64'h1, 64'h5555aaaa5555aaaa};
        foreach (edge_keys[k]) send_op(CMD_PUT, edge_keys[k], k[0] ? 32'hffffffff : 32'h0);
        foreach (edge_keys[k]) send_op(CMD_GET, edge_keys[k], 32'hdeadbeef);
        send_op(CMD_PUT, edge_keys[0], 32'ha5a5a5a5);
        send_op(CMD_SPARE, edge_keys[0], '0);
        send_op(CMD_REMOVE, edge_keys[1], '0);
        send_op(CMD_REMOVE, edge_keys[1], '0);
        send_op(CMD_GET, edge_keys[1], '0);
        send_op(CMD_PUT, edge_keys[1], 32'h12345678);
        send_op(CMD_GET, 64'h0123456789abcdef, '0);
    endtask

    // table at a set capacity fills up: load limit, tombstone reuse, probe bound
    task automatic test_small_table(int unsigned cap, int n);
        wait_quiet();
        write_capacity(cap);
        known_keys.delete();
        repeat (n) begin
            logic [1:0] c;
            c = $urandom_range(99) < 50 ? CMD_PUT : ($urandom_range(1) ? CMD_REMOVE : CMD_GET);
            send_op(c, pick_key(), $urandom);
        end
    endtask

    task automatic test_random(int n);
        repeat (n) begin
            logic [1:0] c;
            c = 2'($urandom_range(99) < 45 ? CMD_PUT : $urandom_range(3));
            send_op(c, pick_key(), $urandom);
        end
    endtask

    // long receiver stall while commands keep coming
    task automatic test_backpressure();
        rx_hold = 1'b1;
        stall_cycles = 400;
        test_random(20);
        wait (rx_hold == 1'b0);
    endtask

    // result check
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat status=%0d", o_status);
                errors++;
            end else begin
                t_op_result e;
                e = pending_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_status);
                    errors++;
                end
                if (o_value_out !== e.value) begin
                    $error("value_out exp %h got %h", e.value, o_value_out);
                    errors++;
                end
                if (o_live_entries !== e.live) begin
                    $error("live_entries exp %0d got %0d", e.live, o_live_entries);
                    errors++;
                end
            end
        end
    end

    // result side ready, with hold-off
    always @(posedge i_clk) begin
        if (rx_hold) begin
            i_ready <= 1'b0;
            if (stall_cycles == 0) rx_hold <= 1'b0;
            else stall_cycles <= stall_cycles - 1;
        end else begin
            i_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on accepted beats
    int unsigned quiet_cycles;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || done) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb_quadratic_probe_hash_table: FAIL");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        errors = 0;
        idle_pct = 37;
        rx_hold = 1'b0;
        stall_cycles = 0;
        done = 1'b0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_cmd = CMD_GET;
        i_key = '0;
        i_value_in = '0;
        i_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tbl_live = 0;
        tbl_cap = 1021;
        for (int s = 0; s < DEPTH; s++) tbl_state[s] = SLOT_FREE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_extremes();
        test_backpressure();
        test_random(250);
        idle_pct = 0;
        test_random(150);
        idle_pct = 37;
        test_small_table(2, 40);
        test_small_table(7, 120);
        test_small_table(13, 140);
        test_small_table(1, 20);
        test_small_table(2047, 30);
        test_small_table(1024, 200);
        test_small_table(31, 120);
        wait_quiet();
        done = 1'b1;
        if (errors == 0) $display("tb_quadratic_probe_hash_table: PASS");
        else $display("tb_quadratic_probe_hash_table: FAIL");
        $finish;
    end

endmodule
